// ===== hdl/cr_pkg.sv =====
// shared types, codes and constants for the catmull-rom curve point evaluator
// no dependencies; imported by cr_front, cr_back and the top level
package cr_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int COORD_W        = 32;
  localparam int INDEX_W        = 6;
  localparam int COUNT_W        = 7;
  localparam int PT_W           = 34;
  localparam int QUEUE_DEPTH    = 4;
  localparam int LANES          = 4;
  localparam int AXES           = 3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  localparam logic [1:0] MODE_ERR   = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;
  localparam logic [1:0] MODE_CURVE = 2'd3;

  typedef struct packed {
    logic       is_load;
    logic [1:0] mode;
    logic       lo_ph;
    logic       hi_ph;
  } cr_ctl_t;

endpackage

// ===== hdl/cr_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module cr_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/cr_queue.sv =====
// short register queue between the classifying front and the arithmetic back
// no dependencies
module cr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [NW-1:0]    count;

  assign full  = (count == NW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = slots[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= din;
    end
  end

endmodule

// ===== hdl/cr_front.sv =====
// front end: takes input transfers, sorts loads from evaluations, finds the segment
// and fraction of an evaluation; depends on cr_pkg
module cr_front #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic [cr_pkg::COUNT_W-1:0]                 point_count,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic                                       req_type,
  input  logic [cr_pkg::INDEX_W-1:0]                 point_index,
  input  logic [cr_pkg::AXES*cr_pkg::COORD_W-1:0]    coords,
  input  logic signed [FRAC_BITS+1:0]                curve_param,
  input  logic                                       q_full,
  output logic                                       push,
  output cr_pkg::cr_ctl_t                            ctl,
  output logic [AW-1:0]                              addr,
  output logic [FRAC_BITS-1:0]                       frac,
  output logic [cr_pkg::AXES*cr_pkg::COORD_W-1:0]    data
);

  import cr_pkg::*;

  logic [CW-1:0]           n;
  logic [CW-1:0]           nm1;
  logic [CW-1:0]           nm2;
  logic [FRAC_BITS+CW-1:0] s;
  logic [CW-1:0]           seg_raw;
  logic [CW-1:0]           seg;
  logic                    t_le0;
  logic                    t_ge1;
  logic                    in_range;

  always_comb begin
    n = (32'(point_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(point_count);
    nm1 = n - CW'(1);
    nm2 = n - CW'(2);
    t_le0 = curve_param[FRAC_BITS+1] || (curve_param == '0);
    t_ge1 = !curve_param[FRAC_BITS+1] && curve_param[FRAC_BITS];
    s = curve_param[FRAC_BITS-1:0] * nm1;
    seg_raw = s[FRAC_BITS+CW-1:FRAC_BITS];
    seg = (seg_raw > nm2) ? nm2 : seg_raw;
    frac = s[FRAC_BITS-1:0];
    in_range = 32'(point_index) < MAX_POINTS;

    in_ready = !q_full;
    push = in_valid && !q_full && ((req_type == REQ_EVAL) || in_range);

    ctl.is_load = (req_type == REQ_LOAD);
    ctl.lo_ph = (seg == '0);
    ctl.hi_ph = (seg == nm2);
    if (n == '0) begin
      ctl.mode = MODE_ERR;
    end else if (t_le0) begin
      ctl.mode = MODE_FIRST;
    end else if (t_ge1) begin
      ctl.mode = MODE_LAST;
    end else if (n < CW'(3)) begin
      ctl.mode = MODE_ERR;
    end else begin
      ctl.mode = MODE_CURVE;
    end

    if (ctl.is_load) begin
      addr = AW'(point_index);
    end else begin
      case (ctl.mode)
        MODE_LAST:  addr = AW'(nm1);
        MODE_CURVE: addr = AW'(seg);
        default:    addr = '0;
      endcase
    end
    data = coords;
  end

endmodule

// ===== hdl/cr_back.sv =====
// back end: owns the point tables, performs loads and runs the blend pipeline
// depends on cr_pkg and cr_ram
module cr_back #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 16,
  parameter int AW         = 6
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    q_valid,
  output logic                                    q_pop,
  input  cr_pkg::cr_ctl_t                         q_ctl,
  input  logic [AW-1:0]                           q_addr,
  input  logic [FRAC_BITS-1:0]                    q_frac,
  input  logic [cr_pkg::AXES*cr_pkg::COORD_W-1:0] q_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [cr_pkg::AXES*cr_pkg::COORD_W-1:0] out_data,
  output logic                                    out_err
);

  import cr_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int WW = F + 4;
  localparam int PW = PT_W + WW;
  localparam int SW = PW + 2;
  localparam int DW = AXES * COORD_W;
  localparam logic [2*F-1:0]        HALF    = (2*F)'(1) << (F - 1);
  localparam logic signed [WW-1:0]  TWO_ONE = WW'(2) << F;
  localparam logic signed [SW-1:0]  RND     = SW'(1) << F;
  localparam logic signed [SW-1:0]  SAT_HI  = SW'(2147483647);
  localparam logic signed [SW-1:0]  SAT_LO  = ~SAT_HI;

  logic en;
  logic pop;
  logic we;
  logic re;
  logic [DW-1:0] rd [LANES];

  assign en    = !out_valid || out_ready;
  assign pop   = en && q_valid;
  assign q_pop = pop;
  assign we    = pop && q_ctl.is_load;
  assign re    = pop && !q_ctl.is_load;

  // one table copy per neighbour lane so all four points come in one read
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    cr_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (q_addr),
      .wdata (q_data),
      .re    (re),
      .raddr (q_addr + AW'(i) - AW'(1)),
      .rdata (rd[i])
    );
  end

  logic                   v1, v2, v3, v4, v5;
  logic [1:0]             m1, m2, m3;
  logic                   lo1, hi1;
  logic                   e4, e5;
  logic [F-1:0]           u1, u2a, u3a;
  logic [F-1:0]           sq2, sq3, cu3;
  logic signed [PT_W-1:0] p2 [LANES][AXES];
  logic signed [PT_W-1:0] p3 [LANES][AXES];
  logic signed [PT_W-1:0] p4 [LANES][AXES];
  logic signed [PT_W-1:0] pn [LANES][AXES];
  logic signed [WW-1:0]   w4 [LANES];
  logic signed [WW-1:0]   wn [LANES];
  logic signed [PW-1:0]   pr5 [LANES][AXES];
  logic [2*F-1:0]         sq_full;
  logic [2*F-1:0]         cu_full;
  logic signed [WW-1:0]   su, su2, su3;
  logic signed [SW-1:0]   acc [AXES];
  logic signed [SW-1:0]   rs [AXES];
  logic [DW-1:0]          res;

  // neighbour points with end phantoms, masked for end and error requests
  always_comb begin
    for (int c = 0; c < AXES; c++) begin
      for (int k = 0; k < LANES; k++) begin
        pn[k][c] = PT_W'($signed(rd[k][c*COORD_W +: COORD_W]));
      end
      if (lo1) begin
        pn[0][c] = (pn[1][c] <<< 1) - pn[2][c];
      end
      if (hi1) begin
        pn[3][c] = (pn[2][c] <<< 1) - pn[1][c];
      end
      if (m1 != MODE_CURVE) begin
        pn[0][c] = '0;
        pn[2][c] = '0;
        pn[3][c] = '0;
      end
      if (m1 == MODE_ERR) begin
        pn[1][c] = '0;
      end
    end
    sq_full = u2a * u2a + HALF;
    sq2 = sq_full[2*F-1:F];
    cu_full = sq3 * u3a + HALF;
    cu3 = cu_full[2*F-1:F];
  end

  // doubled catmull-rom weights; end requests pass the middle point through
  always_comb begin
    su  = $signed(WW'(u3a));
    su2 = $signed(WW'(sq3));
    su3 = $signed(WW'(cu3));
    wn[0] = -su3 + (su2 <<< 1) - su;
    wn[1] = su3 + su3 + su3 - (su2 <<< 2) - su2 + TWO_ONE;
    wn[2] = -(su3 + su3 + su3) + (su2 <<< 2) + su;
    wn[3] = su3 - su2;
    if (m3 != MODE_CURVE) begin
      wn[0] = '0;
      wn[1] = (m3 == MODE_ERR) ? '0 : TWO_ONE;
      wn[2] = '0;
      wn[3] = '0;
    end
  end

  // sum, round half up and saturate
  always_comb begin
    for (int c = 0; c < AXES; c++) begin
      acc[c] = SW'(pr5[0][c]) + SW'(pr5[1][c]) + SW'(pr5[2][c]) + SW'(pr5[3][c]);
      rs[c] = (acc[c] + RND) >>> (F + 1);
      if (rs[c] > SAT_HI) begin
        res[c*COORD_W +: COORD_W] = SAT_HI[COORD_W-1:0];
      end else if (rs[c] < SAT_LO) begin
        res[c*COORD_W +: COORD_W] = SAT_LO[COORD_W-1:0];
      end else begin
        res[c*COORD_W +: COORD_W] = rs[c][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= re;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= q_ctl.mode;
      lo1 <= q_ctl.lo_ph;
      hi1 <= q_ctl.hi_ph;
      u1  <= q_frac;
      m2  <= m1;
      u2a <= u1;
      p2  <= pn;
      m3  <= m2;
      u3a <= u2a;
      // squared fraction travels into stage three
      sq3 <= sq2;
      p3  <= p2;
      e4  <= (m3 == MODE_ERR);
      w4  <= wn;
      p4  <= p3;
      e5  <= e4;
      for (int c = 0; c < AXES; c++) begin
        for (int k = 0; k < LANES; k++) begin
          pr5[k][c] <= p4[k][c] * w4[k];
        end
      end
      out_data <= res;
      out_err  <= e5;
    end
  end

endmodule

// ===== hdl/catmull_rom_curve_point_eval_core.sv =====
// top level of the catmull-rom curve point evaluator
// depends on cr_pkg, cr_front, cr_queue and cr_back
//
// Load transfers write one 3D control point (signed Q16.16) into the point table;
// evaluate transfers give one point on the uniform Catmull-Rom curve through the
// first point_count entries, with phantom end points 2*P0-P1 and 2*Pn-1 - Pn-2.
// One transfer is taken per clock when the result side keeps up; an evaluation
// passes through the back end pipeline of read, square, cube, weights, products
// and final sum. A four-entry queue separates the front from the back, so the
// input keeps flowing through short output stalls.
// count_error (tuser) is set with zero coordinates when the table holds no point,
// or fewer than three for a parameter strictly between 0 and 1.
module catmull_rom_curve_point_eval_core #(
  parameter int MAX_POINTS = cr_pkg::DEF_MAX_POINTS,
  parameter int FRAC_BITS  = cr_pkg::DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cr_pkg::COUNT_W-1:0]    cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_index, coord_x, coord_y, coord_z, curve_param, zero fill
  input  logic [((cr_pkg::INDEX_W + 3*cr_pkg::COORD_W + FRAC_BITS + 2 + 7) / 8) * 8 - 1:0]
                                        s_axis_tdata,
  // req_type
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // point_x, point_y, point_z
  output logic [3*cr_pkg::COORD_W-1:0]  m_axis_tdata,
  // count_error
  output logic                          m_axis_tuser
);

  import cr_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int DW  = AXES * COORD_W;
  localparam int QW  = $bits(cr_ctl_t) + AW + FRAC_BITS + DW;
  localparam int T_LO = INDEX_W + DW;

  logic [COUNT_W-1:0]        point_count;
  logic                      q_full;
  logic                      push;
  cr_ctl_t                   f_ctl;
  logic [AW-1:0]             f_addr;
  logic [FRAC_BITS-1:0]      f_frac;
  logic [DW-1:0]             f_data;
  logic [QW-1:0]             q_out;
  logic                      q_valid;
  logic                      q_pop;
  cr_ctl_t                   b_ctl;
  logic [AW-1:0]             b_addr;
  logic [FRAC_BITS-1:0]      b_frac;
  logic [DW-1:0]             b_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (cfg_we) begin
      point_count <= cfg_wdata;
    end
  end

  cr_front #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW),
    .CW         (CW)
  ) u_front (
    .point_count (point_count),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .req_type    (s_axis_tuser),
    .point_index (s_axis_tdata[INDEX_W-1:0]),
    .coords      (s_axis_tdata[INDEX_W +: DW]),
    .curve_param ($signed(s_axis_tdata[T_LO +: FRAC_BITS + 2])),
    .q_full      (q_full),
    .push        (push),
    .ctl         (f_ctl),
    .addr        (f_addr),
    .frac        (f_frac),
    .data        (f_data)
  );

  cr_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   ({f_ctl, f_addr, f_frac, f_data}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  assign {b_ctl, b_addr, b_frac, b_data} = q_out;

  cr_back #(
    .MAX_POINTS (MAX_POINTS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctl     (b_ctl),
    .q_addr    (b_addr),
    .q_frac    (b_frac),
    .q_data    (b_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_err   (m_axis_tuser)
  );

  // an error result never carries coordinates
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("count error result with nonzero coordinates");

  // a blocked result stalls the back end, so nothing leaves the queue
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !q_pop)
    else $error("queue popped while output stalled");

  // input is held off only by a full queue, which then has work for the back end
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_valid)
    else $error("input held off with empty queue");

endmodule
